### rtl/dsp_instruction_decoder_defines.svh
// Assertion macros for the instruction decoder.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef DSP_INSTRUCTION_DECODER_DEFINES_SVH
`define DSP_INSTRUCTION_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

`define DSPID_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("dspid assertion failed");

`define DSPID_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dspid implication failed");

`else

`define DSPID_ASSERT(lbl, prop)

`define DSPID_ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

### rtl/dspid_pkg.sv
package dspid_pkg;

  // instruction type codes, bits 31..29
  localparam logic [2:0] TY_MOVE  = 3'd0;
  localparam logic [2:0] TY_ALU   = 3'd1;
  localparam logic [2:0] TY_PFLOW = 3'd5;
  localparam logic [2:0] TY_SYS   = 3'd6;

  // move opcodes, bits 28..26
  localparam logic [2:0] MV_BRM = 3'd1;
  localparam logic [2:0] MV_BRR = 3'd3;
  localparam logic [2:0] MV_LD  = 3'd6;

  // largest legal opcode values
  localparam logic [2:0] ALU_OP_MAX   = 3'd2;
  localparam logic [4:0] ALU_ARTH_MAX = 5'd2;
  localparam logic [2:0] ALU_SHFT_MAX = 3'd2;
  localparam logic [3:0] FLOW_OP_MAX  = 4'd1;

  typedef struct packed {
    logic        illegal;
    logic [2:0]  op_type;
    logic [2:0]  op_main;
    logic [1:0]  op_arith;
    logic [1:0]  op_shift;
    logic [1:0]  src_dst_sel;
    logic [1:0]  addr_mode;
    logic [15:0] immediate;
    logic [4:0]  src_reg_a;
    logic [4:0]  src_reg_b;
    logic [4:0]  dest_reg;
  } dec_result_t;

endpackage

### rtl/dspid_decode.sv
module dspid_decode (
  input  logic [31:0]              instr_i,
  output dspid_pkg::dec_result_t   res_o
);
  import dspid_pkg::*;

  dec_result_t res;
  logic        bad;
  logic [2:0]  ty;

  assign ty = instr_i[31:29];

  always_comb begin
    res         = '0;
    bad         = 1'b0;
    res.op_type = ty;
    unique case (ty)
      TY_MOVE: begin
        res.op_main = instr_i[28:26];
        unique case (instr_i[28:26])
          MV_BRM: begin
            res.src_dst_sel = instr_i[22:21];
            res.src_reg_a   = instr_i[9:5];
            res.dest_reg    = instr_i[4:0];
          end
          MV_BRR: begin
            res.src_reg_a = instr_i[9:5];
            res.dest_reg  = instr_i[4:0];
          end
          MV_LD: begin
            res.src_dst_sel = instr_i[22:21];
            res.immediate   = instr_i[20:5];
            res.dest_reg    = instr_i[4:0];
          end
          default: bad = 1'b1;
        endcase
      end
      TY_ALU: begin
        // mode above 3 means bit 17 set
        if (instr_i[28:26] > ALU_OP_MAX || instr_i[25:21] > ALU_ARTH_MAX ||
            instr_i[20:18] > ALU_SHFT_MAX || instr_i[17]) begin
          bad = 1'b1;
        end else begin
          res.op_main   = instr_i[28:26];
          res.op_arith  = instr_i[22:21];
          res.op_shift  = instr_i[19:18];
          res.addr_mode = instr_i[16:15];
          res.dest_reg  = instr_i[4:0];
          if (instr_i[15]) begin
            res.immediate = {6'd0, instr_i[14:5]};
          end else begin
            res.src_reg_a = instr_i[14:10];
            res.src_reg_b = instr_i[9:5];
          end
        end
      end
      TY_PFLOW: begin
        if (instr_i[28:25] > FLOW_OP_MAX) begin
          bad = 1'b1;
        end else begin
          res.op_main     = {2'd0, instr_i[25]};
          // only bit 23 carries s/d here
          res.src_dst_sel = {1'b0, instr_i[23]};
          if (instr_i[23]) begin
            res.immediate = instr_i[15:0];
          end else begin
            res.dest_reg = instr_i[4:0];
          end
        end
      end
      TY_SYS: begin
        if (instr_i[28:25] > FLOW_OP_MAX) begin
          bad = 1'b1;
        end else begin
          res.op_main   = {2'd0, instr_i[25]};
          res.immediate = {8'd0, instr_i[7:0]};
        end
      end
      default: bad = 1'b1;
    endcase

    if (bad) begin
      res         = '0;
      res.illegal = 1'b1;
    end
  end

  assign res_o = res;

endmodule

### rtl/dsp_instruction_decoder.sv
// Channel  | Ports                          | Handshake
// ---------+--------------------------------+----------------------------------
// request  | start_i, instr_word_i          | taken when start_i && !busy_o
// result   | valid_o, illegal_o .. dest_reg_o | one-cycle strobe on valid_o
//
// One request per cycle; busy_o never rises.
// The path runs through the instruction register, the decode logic and the result register.
// Reset clears both stage valid bits; payload registers are not reset.
// The receiver cannot stall, so no result is ever held back.
`include "dsp_instruction_decoder_defines.svh"

module dsp_instruction_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] instr_word_i,
  output logic        busy_o,
  output logic        valid_o,
  output logic        illegal_o,
  output logic [2:0]  op_type_o,
  output logic [2:0]  op_main_o,
  output logic [1:0]  op_arith_o,
  output logic [1:0]  op_shift_o,
  output logic [1:0]  src_dst_sel_o,
  output logic [1:0]  addr_mode_o,
  output logic [15:0] immediate_o,
  output logic [4:0]  src_reg_a_o,
  output logic [4:0]  src_reg_b_o,
  output logic [4:0]  dest_reg_o
);
  import dspid_pkg::*;

  logic        in_valid_q, in_valid_d;
  logic [31:0] word_q, word_d;
  logic        out_valid_q, out_valid_d;
  dec_result_t res_q, res_d;

  assign busy_o = 1'b0;

  assign in_valid_d  = start_i && !busy_o;
  assign word_d      = instr_word_i;
  assign out_valid_d = in_valid_q;

  dspid_decode u_decode (
    .instr_i (word_q),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_d) begin
      word_q <= word_d;
    end
    if (in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign valid_o       = out_valid_q;
  assign illegal_o     = res_q.illegal;
  assign op_type_o     = res_q.op_type;
  assign op_main_o     = res_q.op_main;
  assign op_arith_o    = res_q.op_arith;
  assign op_shift_o    = res_q.op_shift;
  assign src_dst_sel_o = res_q.src_dst_sel;
  assign addr_mode_o   = res_q.addr_mode;
  assign immediate_o   = res_q.immediate;
  assign src_reg_a_o   = res_q.src_reg_a;
  assign src_reg_b_o   = res_q.src_reg_b;
  assign dest_reg_o    = res_q.dest_reg;

  // every accepted request yields a strobe on valid_o
  `DSPID_ASSERT(a_req_to_result, start_i && !busy_o |-> ##2 valid_o)
  // a strobe only follows a request
  `DSPID_ASSERT_IMPL(a_no_spurious, valid_o, $past(start_i, 2))
  // an illegal word carries nothing else
  `DSPID_ASSERT_IMPL(a_illegal_zero, valid_o && illegal_o,
    op_type_o == 3'd0 && op_main_o == 3'd0 && immediate_o == 16'd0 &&
    src_reg_a_o == 5'd0 && dest_reg_o == 5'd0 && src_dst_sel_o == 2'd0)
  // ALU-only fields stay clear for the other types
  `DSPID_ASSERT_IMPL(a_alu_fields, valid_o && op_type_o != TY_ALU,
    op_arith_o == 2'd0 && op_shift_o == 2'd0 && addr_mode_o == 2'd0 &&
    src_reg_b_o == 5'd0)

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import dspid_pkg::*;

  localparam logic [2:0] ALU_MODE_MAX = 3'd3;
  localparam int unsigned GAP_MAX     = 5;
  localparam int unsigned NUM_RANDOM  = 630;
  localparam int unsigned STALL_LIMIT = 100;
  localparam int unsigned TAIL_CYCLES = 6;

  typedef struct {
    logic [31:0] word;
    int unsigned gap;
    bit          drain;
  } instr_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [31:0] instr_word_i = '0;
  logic        busy_o;
  logic        valid_o;
  logic        illegal_o;
  logic [2:0]  op_type_o;
  logic [2:0]  op_main_o;
  logic [1:0]  op_arith_o;
  logic [1:0]  op_shift_o;
  logic [1:0]  src_dst_sel_o;
  logic [1:0]  addr_mode_o;
  logic [15:0] immediate_o;
  logic [4:0]  src_reg_a_o;
  logic [4:0]  src_reg_b_o;
  logic [4:0]  dest_reg_o;

  instr_req_t  instr_pending_q[$];
  dec_result_t decoded_expect_q[$];
  instr_req_t  staged_req;
  bit          req_staged = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_cycles = 0;
  int unsigned err_cnt = 0;
  bit          timed_out = 1'b0;

  dsp_instruction_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .instr_word_i  (instr_word_i),
    .busy_o        (busy_o),
    .valid_o       (valid_o),
    .illegal_o     (illegal_o),
    .op_type_o     (op_type_o),
    .op_main_o     (op_main_o),
    .op_arith_o    (op_arith_o),
    .op_shift_o    (op_shift_o),
    .src_dst_sel_o (src_dst_sel_o),
    .addr_mode_o   (addr_mode_o),
    .immediate_o   (immediate_o),
    .src_reg_a_o   (src_reg_a_o),
    .src_reg_b_o   (src_reg_b_o),
    .dest_reg_o    (dest_reg_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic dec_result_t decode_word(logic [31:0] w);
    dec_result_t r;
    bit bad;
    r = '0;
    bad = 1'b0;
    r.op_type = w[31:29];
    case (w[31:29])
      TY_MOVE: begin
        r.op_main = w[28:26];
        r.dest_reg = w[4:0];
        case (w[28:26])
          MV_BRM: begin
            r.src_dst_sel = w[22:21];
            r.src_reg_a = w[9:5];
          end
          MV_BRR: r.src_reg_a = w[9:5];
          MV_LD: begin
            r.src_dst_sel = w[22:21];
            r.immediate = w[20:5];
          end
          default: bad = 1'b1;
        endcase
      end
      TY_ALU: begin
        if (w[28:26] > ALU_OP_MAX || w[25:21] > ALU_ARTH_MAX ||
            w[20:18] > ALU_SHFT_MAX || w[17:15] > ALU_MODE_MAX) begin
          bad = 1'b1;
        end else begin
          r.op_main = w[28:26];
          r.op_arith = w[22:21];
          r.op_shift = w[19:18];
          r.addr_mode = w[16:15];
          r.dest_reg = w[4:0];
          // odd mode carries imm10 in place of both source registers
          if (w[15]) begin
            r.immediate = {6'b0, w[14:5]};
          end else begin
            r.src_reg_a = w[14:10];
            r.src_reg_b = w[9:5];
          end
        end
      end
      TY_PFLOW: begin
        if (w[28:25] > FLOW_OP_MAX) begin
          bad = 1'b1;
        end else begin
          r.op_main = w[27:25];
          // only bit 23 is s/d, bit 22 is don't-care
          r.src_dst_sel = {1'b0, w[23]};
          if (w[23]) r.immediate = w[15:0];
          else r.dest_reg = w[4:0];
        end
      end
      TY_SYS: begin
        if (w[28:25] > FLOW_OP_MAX) bad = 1'b1;
        else begin
          r.op_main = w[27:25];
          r.immediate = {8'b0, w[7:0]};
        end
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      r = '0;
      r.illegal = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [31:0] alu_word(logic [2:0] om, logic [4:0] oa, logic [2:0] os,
                                           logic [2:0] am, logic [14:0] low);
    return {TY_ALU, om, oa, os, am, low};
  endfunction

  task automatic add_req(logic [31:0] word, int unsigned gap, bit drain);
    instr_req_t req;
    req.word = word;
    req.gap = gap;
    req.drain = drain;
    instr_pending_q.push_back(req);
  endtask

  function automatic logic [31:0] random_word();
    int unsigned kind;
    logic [2:0] ty;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      case ($urandom_range(0, 2))
        0: ty = MV_BRM;
        1: ty = MV_BRR;
        default: ty = MV_LD;
      endcase
      return {TY_MOVE, ty, 26'($urandom)};
    end else if (kind < 45) begin
      return alu_word(3'($urandom_range(0, ALU_OP_MAX)), 5'($urandom_range(0, ALU_ARTH_MAX)),
                      3'($urandom_range(0, ALU_SHFT_MAX)), 3'($urandom_range(0, ALU_MODE_MAX)),
                      15'($urandom));
    end else if (kind < 60) begin
      return {TY_PFLOW, 4'($urandom_range(0, FLOW_OP_MAX)), 25'($urandom)};
    end else if (kind < 72) begin
      return {TY_SYS, 4'($urandom_range(0, FLOW_OP_MAX)), 25'($urandom)};
    end else if (kind < 88) begin
      // known type, opcode and mode bits left fully random
      case ($urandom_range(0, 3))
        0: ty = TY_MOVE;
        1: ty = TY_ALU;
        2: ty = TY_PFLOW;
        default: ty = TY_SYS;
      endcase
      return {ty, 29'($urandom)};
    end
    return $urandom;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      err_cnt++;
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      instr_word_i <= '0;
      req_staged = 1'b0;
      gap_left = 0;
    end else if (!(start_i && busy_o)) begin
      if (!req_staged && instr_pending_q.size() > 0) begin
        staged_req = instr_pending_q.pop_front();
        req_staged = 1'b1;
        gap_left = staged_req.gap;
      end
      // a drain request waits until nothing is in flight
      if (req_staged && gap_left == 0 &&
          !(staged_req.drain && (start_i || decoded_expect_q.size() != 0))) begin
        start_i <= 1'b1;
        instr_word_i <= staged_req.word;
        req_staged = 1'b0;
      end else begin
        start_i <= 1'b0;
        if (req_staged && gap_left > 0) gap_left--;
      end
    end
  end

  // monitor: results are checked before the request taken at the same edge is queued
  always @(posedge clk_i) begin
    dec_result_t exp_r;
    bit req_taken;
    if (rst_ni) begin
      req_taken = start_i && !busy_o;
      if ($isunknown(valid_o)) begin
        $error("valid_o unknown");
        err_cnt++;
      end
      if (valid_o) begin
        if (decoded_expect_q.size() == 0) begin
          $error("result with no request outstanding");
          err_cnt++;
        end else begin
          exp_r = decoded_expect_q.pop_front();
          check_field("illegal", exp_r.illegal, illegal_o);
          check_field("op_type", exp_r.op_type, op_type_o);
          check_field("op_main", exp_r.op_main, op_main_o);
          check_field("op_arith", exp_r.op_arith, op_arith_o);
          check_field("op_shift", exp_r.op_shift, op_shift_o);
          check_field("src_dst_sel", exp_r.src_dst_sel, src_dst_sel_o);
          check_field("addr_mode", exp_r.addr_mode, addr_mode_o);
          check_field("immediate", exp_r.immediate, immediate_o);
          check_field("src_reg_a", exp_r.src_reg_a, src_reg_a_o);
          check_field("src_reg_b", exp_r.src_reg_b, src_reg_b_o);
          check_field("dest_reg", exp_r.dest_reg, dest_reg_o);
        end
      end
      if (req_taken) decoded_expect_q.push_back(decode_word(instr_word_i));
      if (req_taken || valid_o) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  initial begin
    bit no_gaps;
    int unsigned gap;
    logic [2:0] op3;
    logic [3:0] op4;

    // move: every opcode, payload alternating all ones / all zeros
    for (int op = 0; op < 8; op++) begin
      op3 = 3'(op);
      add_req({TY_MOVE, op3, op[0] ? 26'h3FF_FFFF : 26'h0}, 0, 1'b0);
    end
    add_req({TY_MOVE, MV_LD, 26'h3FF_FFFF}, 0, 1'b0);
    add_req({TY_MOVE, MV_BRM, 26'h0}, 1, 1'b0);
    // alu: every legal mode at the largest opcodes, then each check failing
    for (int m = 0; m <= ALU_MODE_MAX; m++) begin
      add_req(alu_word(ALU_OP_MAX, ALU_ARTH_MAX, ALU_SHFT_MAX, 3'(m), m[0] ? '1 : 15'h0), 0,
              1'b0);
    end
    add_req(alu_word(ALU_OP_MAX + 3'd1, '0, '0, '0, '1), 0, 1'b0);
    add_req(alu_word('0, '1, '0, '0, '1), 0, 1'b0);
    add_req(alu_word('0, '0, ALU_SHFT_MAX + 3'd1, '0, '1), 0, 1'b0);
    add_req(alu_word('0, '0, '0, ALU_MODE_MAX + 3'd1, '1), 0, 1'b0);
    // program flow: s/d clear and set, ignored bit 22, bad opcodes
    op4 = FLOW_OP_MAX;
    add_req({TY_PFLOW, 4'h0, 25'h07F_FFFF}, 0, 1'b0);
    add_req({TY_PFLOW, op4, 25'h1FF_FFFF}, 0, 1'b0);
    add_req({TY_PFLOW, op4, 25'h040_001F}, 0, 1'b0);
    add_req({TY_PFLOW, FLOW_OP_MAX + 4'h1, 25'h0}, 0, 1'b0);
    add_req({TY_PFLOW, 4'hF, 25'h1FF_FFFF}, 0, 1'b0);
    // system
    add_req({TY_SYS, 4'h0, 25'h1FF_FFFF}, 0, 1'b0);
    add_req({TY_SYS, op4, 25'h0}, 0, 1'b0);
    add_req({TY_SYS, 4'hF, 25'h1FF_FFFF}, 0, 1'b0);
    // unassigned types
    for (int t = 0; t < 8; t++) begin
      op3 = 3'(t);
      if (op3 != TY_MOVE && op3 != TY_ALU && op3 != TY_PFLOW && op3 != TY_SYS)
        add_req({op3, 29'($urandom)}, 0, 1'b0);
    end

    no_gaps = 1'b0;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      // choose at random between back-to-back stretches and gappy ones
      if (i % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      gap = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
      add_req(random_word(), gap, i == 0 || $urandom_range(0, 59) == 0);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!timed_out && !(instr_pending_q.size() == 0 && !req_staged && !start_i &&
                           decoded_expect_q.size() == 0)) begin
      @(posedge clk_i);
      if (stall_cycles >= STALL_LIMIT) timed_out = 1'b1;
    end
    if (!timed_out) repeat (TAIL_CYCLES) @(posedge clk_i);

    if (timed_out) begin
      $display("watchdog expired, %0d requests outstanding", decoded_expect_q.size());
      $display("[FAIL] regression broken");
    end else if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### dsp_instruction_decoder.f
+incdir+rtl
rtl/dspid_pkg.sv
rtl/dspid_decode.sv
rtl/dsp_instruction_decoder.sv
bench/tb.sv
